// ----- sv/slm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types, register map, band codes and mapping constants of the
// peak-to-peak sound level meter.
// ----------------------------------------------------------------------------
package slm_pkg;

   // field widths
   localparam int ADC_BITS      = 12;
   localparam int AVG_FRAC_BITS = 4;
   localparam int WIN_BITS      = 10;
   localparam int PERIOD_BITS   = 16;
   localparam int LEVEL_BITS    = 12;
   localparam int BAND_BITS     = 2;
   localparam int AVG_BITS      = 16;
   localparam int SUM_BITS      = 28;
   localparam int COUNT_BITS    = 16;

   // average divider
   localparam int DIV_BITS     = SUM_BITS + AVG_FRAC_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

   // register port
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 3;

   localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_MS     = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_AVG_WINDOW_MS = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_QUIET_LOW     = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_MODERATE_LOW  = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_LOUD_LOW      = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_LOUD_HIGH     = 3'd5;

   // register reset values
   localparam logic [WIN_BITS-1:0]    WINDOW_MS_RESET     = 10'd50;
   localparam logic [PERIOD_BITS-1:0] AVG_WINDOW_MS_RESET = 16'd20000;
   localparam logic [WIN_BITS-1:0]    QUIET_LOW_RESET     = 10'd30;
   localparam logic [WIN_BITS-1:0]    MODERATE_LOW_RESET  = 10'd50;
   localparam logic [WIN_BITS-1:0]    LOUD_LOW_RESET      = 10'd80;
   localparam logic [WIN_BITS-1:0]    LOUD_HIGH_RESET     = 10'd100;

   // band codes
   localparam logic [BAND_BITS-1:0] BAND_OFF      = 2'd0;
   localparam logic [BAND_BITS-1:0] BAND_QUIET    = 2'd1;
   localparam logic [BAND_BITS-1:0] BAND_MODERATE = 2'd2;
   localparam logic [BAND_BITS-1:0] BAND_LOUD     = 2'd3;

   // level = (p - 150) * 77 / 185 + 28, quotient by reciprocal plus one fixup
   localparam int     MAP_OFFSET     = 150;
   localparam int     MAP_NUM        = 77;
   localparam int     MAP_DEN        = 185;
   localparam int     MAP_BIAS       = 28;
   localparam int     MAP_SHIFT      = 24;
   localparam longint MAP_RECIP      = ((longint'(1) << MAP_SHIFT) * MAP_NUM) / MAP_DEN;
   localparam int     MAP_RECIP_BITS = $clog2(MAP_RECIP + 1);
   localparam int     FIX_BITS       = ADC_BITS + 8;
   localparam int     LV_BITS        = (ADC_BITS + 2 > LEVEL_BITS + 1) ?
                                       ADC_BITS + 2 : LEVEL_BITS + 1;
   localparam int     BAND_CMP_BITS  = LEVEL_BITS + 1;

   // input transaction
   typedef struct packed {
      logic [ADC_BITS-1:0] sample;
      logic                ms_tick;
   } slm_req_type;

   // result transaction
   typedef struct packed {
      logic                         level_valid;
      logic signed [LEVEL_BITS-1:0] level_db;
      logic [BAND_BITS-1:0]         band;
      logic                         avg_valid;
      logic signed [AVG_BITS-1:0]   avg_db_q4;
   } slm_rsp_type;

   // configuration registers
   typedef struct packed {
      logic [WIN_BITS-1:0]    window_ms;
      logic [PERIOD_BITS-1:0] avg_window_ms;
      logic [WIN_BITS-1:0]    quiet_low;
      logic [WIN_BITS-1:0]    moderate_low;
      logic [WIN_BITS-1:0]    loud_low;
      logic [WIN_BITS-1:0]    loud_high;
   } slm_cfg_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic map;
      logic fix;
      logic accum;
      logic div_step;
      logic out_load;
   } slm_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic close;
      logic avg_due;
      logic div_last;
      logic out_free;
   } slm_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAP,
      S_FIX,
      S_ACCUM,
      S_DIV,
      S_OUT
   } slm_state_type;

endpackage
`default_nettype wire

// ----- sv/slm_csr.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slm_csr
// Register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module slm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [slm_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [slm_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [slm_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready,
   output slm_pkg::slm_cfg_type               cfg
);
   import slm_pkg::*;

   slm_cfg_type               cfg_ff;
   slm_cfg_type               cfg_in;
   logic                      wr_en;
   logic [REG_IDX_BITS-1:0]   idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_paddr[REG_IDX_BITS+1:2];
   assign cfg        = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_WINDOW_MS:     cfg_in.window_ms     = csr_pwdata[WIN_BITS-1:0];
            REG_AVG_WINDOW_MS: cfg_in.avg_window_ms = csr_pwdata[PERIOD_BITS-1:0];
            REG_QUIET_LOW:     cfg_in.quiet_low     = csr_pwdata[WIN_BITS-1:0];
            REG_MODERATE_LOW:  cfg_in.moderate_low  = csr_pwdata[WIN_BITS-1:0];
            REG_LOUD_LOW:      cfg_in.loud_low      = csr_pwdata[WIN_BITS-1:0];
            REG_LOUD_HIGH:     cfg_in.loud_high     = csr_pwdata[WIN_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms     <= WINDOW_MS_RESET;
         cfg_ff.avg_window_ms <= AVG_WINDOW_MS_RESET;
         cfg_ff.quiet_low     <= QUIET_LOW_RESET;
         cfg_ff.moderate_low  <= MODERATE_LOW_RESET;
         cfg_ff.loud_low      <= LOUD_LOW_RESET;
         cfg_ff.loud_high     <= LOUD_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_WINDOW_MS:     csr_prdata = CSR_DATA_BITS'(cfg_ff.window_ms);
         REG_AVG_WINDOW_MS: csr_prdata = CSR_DATA_BITS'(cfg_ff.avg_window_ms);
         REG_QUIET_LOW:     csr_prdata = CSR_DATA_BITS'(cfg_ff.quiet_low);
         REG_MODERATE_LOW:  csr_prdata = CSR_DATA_BITS'(cfg_ff.moderate_low);
         REG_LOUD_LOW:      csr_prdata = CSR_DATA_BITS'(cfg_ff.loud_low);
         REG_LOUD_HIGH:     csr_prdata = CSR_DATA_BITS'(cfg_ff.loud_high);
         default:           csr_prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

// ----- sv/slm_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slm_div
// Restoring unsigned divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module slm_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             step,
   input  logic [slm_pkg::DIV_BITS-1:0]     dividend,
   input  logic [slm_pkg::COUNT_BITS-1:0]   divisor,
   output logic [slm_pkg::DIV_BITS-1:0]     quotient,
   output logic                             last
);
   import slm_pkg::*;

   logic [DIV_BITS-1:0]     quo_ff, quo_in;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [COUNT_BITS-1:0]   dvs_ff, dvs_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [COUNT_BITS:0]     shifted;
   logic [COUNT_BITS+1:0]   trial;
   logic                    fits;

   assign quotient = quo_ff;
   assign last     = (cnt_ff == DIV_CNT_BITS'(DIV_BITS - 1));

   // shift-subtract step
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_BITS-1]};
      trial   = (COUNT_BITS+2)'(shifted) - (COUNT_BITS+2)'(dvs_ff);
      fits    = ~trial[COUNT_BITS+1];
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = '0;
      end else if (step) begin
         quo_in = {quo_ff[DIV_BITS-2:0], fits};
         rem_in = fits ? trial[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // operands
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule
`default_nettype wire

// ----- sv/slm_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slm_dp
// Datapath: window peak tracking, level mapping, band test, running sum
// and count, average division and the result register.
// ----------------------------------------------------------------------------
module slm_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  slm_pkg::slm_req_type     req_data,
   input  slm_pkg::slm_cfg_type     cfg,
   input  slm_pkg::slm_cmd_type     cmd,
   output slm_pkg::slm_status_type  status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output slm_pkg::slm_rsp_type     rsp_data
);
   import slm_pkg::*;

   localparam logic [ADC_BITS-1:0]          ADC_MAX   = '1;
   localparam logic signed [LV_BITS-1:0]    LV_HI     = LV_BITS'((2 ** (LEVEL_BITS - 1)) - 1);
   localparam logic signed [LV_BITS-1:0]    LV_LO     = LV_BITS'(-(2 ** (LEVEL_BITS - 1)));
   localparam logic [DIV_BITS-1:0]          AVG_POS   = DIV_BITS'((2 ** (AVG_BITS - 1)) - 1);
   localparam logic [DIV_BITS-1:0]          AVG_NEG   = DIV_BITS'(2 ** (AVG_BITS - 1));

   // window and averaging state
   logic [WIN_BITS-1:0]           window_elapsed_ff, window_elapsed_in;
   logic [ADC_BITS-1:0]           peak_max_ff, peak_max_in;
   logic [ADC_BITS-1:0]           peak_min_ff, peak_min_in;
   logic [PERIOD_BITS-1:0]        avg_elapsed_ff, avg_elapsed_in;
   logic signed [SUM_BITS-1:0]    level_sum_ff, level_sum_in;
   logic [COUNT_BITS-1:0]         level_count_ff, level_count_in;

   // per-transaction working registers
   logic                          close_ff, close_in;
   logic                          neg_ff, neg_in;
   logic [ADC_BITS-1:0]           mag_ff, mag_in;
   logic [ADC_BITS-1:0]           q0_ff, q0_in;
   logic signed [LEVEL_BITS-1:0]  level_ff, level_in;
   logic [BAND_BITS-1:0]          band_ff, band_in;
   logic                          avg_ff, avg_in;
   logic                          avg_neg_ff, avg_neg_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   slm_rsp_type                   rsp_ff, rsp_in;

   // combinational intermediates
   logic [WIN_BITS:0]                    elapsed;
   logic [ADC_BITS-1:0]                  max_new, min_new, span;
   logic signed [ADC_BITS:0]             diff;
   logic [ADC_BITS+MAP_RECIP_BITS-1:0]   recip_prod;
   logic [FIX_BITS-1:0]                  fix_num, fix_back, fix_rem;
   logic [ADC_BITS-1:0]                  q_fix;
   logic signed [LV_BITS-1:0]            lv_wide;
   logic signed [BAND_CMP_BITS-1:0]      lv_cmp, th_quiet, th_mod, th_loud, th_high;
   logic signed [SUM_BITS:0]             sum_wide;
   logic signed [SUM_BITS-1:0]           sum_next;
   logic [COUNT_BITS-1:0]                count_next;
   logic [SUM_BITS-1:0]                  sum_mag;
   logic                                 avg_due;
   logic                                 div_start;
   logic [DIV_BITS-1:0]                  div_dividend;
   logic [DIV_BITS-1:0]                  div_quotient;
   logic                                 div_last;
   logic signed [AVG_BITS-1:0]           avg_sat;
   logic                                 out_free;

   // sample front end: peaks, window count and distance from the offset
   always_comb begin
      elapsed = {1'b0, window_elapsed_ff} + (WIN_BITS+1)'(req_data.ms_tick);
      max_new = (req_data.sample > peak_max_ff) ? req_data.sample : peak_max_ff;
      min_new = (req_data.sample < peak_min_ff) ? req_data.sample : peak_min_ff;
      span    = max_new - min_new;
      diff    = $signed({1'b0, span}) - (ADC_BITS+1)'(MAP_OFFSET);
   end

   // reciprocal multiply gives the quotient or one less
   assign recip_prod = (ADC_BITS+MAP_RECIP_BITS)'(mag_ff) *
                       (ADC_BITS+MAP_RECIP_BITS)'(MAP_RECIP);

   // remainder fixup, sign and bias; the clamp is applied on the fix step
   always_comb begin
      fix_num  = FIX_BITS'(mag_ff) * FIX_BITS'(MAP_NUM);
      fix_back = FIX_BITS'(q0_ff) * FIX_BITS'(MAP_DEN);
      fix_rem  = fix_num - fix_back;
      q_fix    = q0_ff + ADC_BITS'(fix_rem >= FIX_BITS'(MAP_DEN));
      lv_wide  = $signed(LV_BITS'(q_fix));
      if (neg_ff) begin
         lv_wide = -lv_wide;
      end
      lv_wide = lv_wide + LV_BITS'(MAP_BIAS);
   end

   // band thresholds and running sum
   always_comb begin
      lv_cmp   = BAND_CMP_BITS'(level_ff);
      th_quiet = $signed(BAND_CMP_BITS'(cfg.quiet_low));
      th_mod   = $signed(BAND_CMP_BITS'(cfg.moderate_low));
      th_loud  = $signed(BAND_CMP_BITS'(cfg.loud_low));
      th_high  = $signed(BAND_CMP_BITS'(cfg.loud_high));
      sum_wide = (SUM_BITS+1)'(level_sum_ff) + (SUM_BITS+1)'(level_ff);
      if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
         sum_next = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                       : {1'b0, {(SUM_BITS-1){1'b1}}};
      end else begin
         sum_next = sum_wide[SUM_BITS-1:0];
      end
      count_next   = (level_count_ff == '1) ? level_count_ff : level_count_ff + 1'b1;
      sum_mag      = sum_next[SUM_BITS-1] ? SUM_BITS'(-sum_next) : SUM_BITS'(sum_next);
      div_dividend = DIV_BITS'(sum_mag) << AVG_FRAC_BITS;
      avg_due      = (avg_elapsed_ff >= cfg.avg_window_ms);
      div_start    = cmd.accum & avg_due;
   end

   // average: saturate the signed quotient to the output width
   always_comb begin
      if (avg_neg_ff) begin
         avg_sat = (div_quotient > AVG_NEG) ? AVG_BITS'(AVG_NEG)
                                            : AVG_BITS'(-div_quotient);
      end else begin
         avg_sat = (div_quotient > AVG_POS) ? AVG_BITS'(AVG_POS)
                                            : AVG_BITS'(div_quotient);
      end
   end

   slm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .step     (cmd.div_step),
      .dividend (div_dividend),
      .divisor  (count_next),
      .quotient (div_quotient),
      .last     (div_last)
   );

   // next state of window and average bookkeeping
   always_comb begin
      window_elapsed_in = window_elapsed_ff;
      peak_max_in       = peak_max_ff;
      peak_min_in       = peak_min_ff;
      avg_elapsed_in    = avg_elapsed_ff;
      level_sum_in      = level_sum_ff;
      level_count_in    = level_count_ff;
      if (cmd.accept) begin
         if (req_data.ms_tick && (avg_elapsed_ff != '1)) begin
            avg_elapsed_in = avg_elapsed_ff + 1'b1;
         end
         if (elapsed > (WIN_BITS+1)'(cfg.window_ms)) begin
            window_elapsed_in = '0;
            peak_max_in       = '0;
            peak_min_in       = ADC_MAX;
         end else begin
            window_elapsed_in = elapsed[WIN_BITS-1:0];
            peak_max_in       = max_new;
            peak_min_in       = min_new;
         end
      end
      if (cmd.accum) begin
         if (avg_due) begin
            level_sum_in   = '0;
            level_count_in = '0;
            avg_elapsed_in = '0;
         end else begin
            level_sum_in   = sum_next;
            level_count_in = count_next;
         end
      end
   end

   // next state of the working registers
   always_comb begin
      close_in   = close_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      q0_in      = q0_ff;
      level_in   = level_ff;
      band_in    = band_ff;
      avg_in     = avg_ff;
      avg_neg_in = avg_neg_ff;
      if (cmd.accept) begin
         close_in = (elapsed > (WIN_BITS+1)'(cfg.window_ms));
         neg_in   = diff[ADC_BITS];
         mag_in   = diff[ADC_BITS] ? ADC_BITS'(-diff) : ADC_BITS'(diff);
         avg_in   = 1'b0;
      end
      if (cmd.map) begin
         q0_in = ADC_BITS'(recip_prod[ADC_BITS+MAP_RECIP_BITS-1:MAP_SHIFT]);
      end
      if (cmd.fix) begin
         if (lv_wide > LV_HI) begin
            level_in = LEVEL_BITS'(LV_HI);
         end else if (lv_wide < LV_LO) begin
            level_in = LEVEL_BITS'(LV_LO);
         end else begin
            level_in = LEVEL_BITS'(lv_wide);
         end
      end
      if (cmd.accum) begin
         if (lv_cmp >= th_quiet && lv_cmp < th_mod) begin
            band_in = BAND_QUIET;
         end else if (lv_cmp >= th_mod && lv_cmp < th_loud) begin
            band_in = BAND_MODERATE;
         end else if (lv_cmp >= th_loud && lv_cmp <= th_high) begin
            band_in = BAND_LOUD;
         end else begin
            band_in = BAND_OFF;
         end
         avg_in     = avg_due;
         avg_neg_in = sum_next[SUM_BITS-1];
      end
   end

   // result register
   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (cmd.out_load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.level_valid = close_ff;
         rsp_in.level_db    = close_ff ? level_ff : '0;
         rsp_in.band        = close_ff ? band_ff : BAND_OFF;
         rsp_in.avg_valid   = close_ff & avg_ff;
         rsp_in.avg_db_q4   = (close_ff && avg_ff) ? avg_sat : '0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_elapsed_ff <= '0;
         peak_max_ff       <= '0;
         peak_min_ff       <= ADC_MAX;
         avg_elapsed_ff    <= '0;
         level_sum_ff      <= '0;
         level_count_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         window_elapsed_ff <= window_elapsed_in;
         peak_max_ff       <= peak_max_in;
         peak_min_ff       <= peak_min_in;
         avg_elapsed_ff    <= avg_elapsed_in;
         level_sum_ff      <= level_sum_in;
         level_count_ff    <= level_count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      close_ff   <= close_in;
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      q0_ff      <= q0_in;
      level_ff   <= level_in;
      band_ff    <= band_in;
      avg_ff     <= avg_in;
      avg_neg_ff <= avg_neg_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      status.close    = (elapsed > (WIN_BITS+1)'(cfg.window_ms));
      status.avg_due  = avg_due;
      status.div_last = div_last;
      status.out_free = out_free;
   end

`ifndef SYNTHESIS
   // an empty average holds no sum
   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      (level_count_ff == '0) |-> (level_sum_ff == '0))
      else $error("level sum nonzero with zero count");

   // peaks are ordered unless the window was just cleared
   a_peak_order: assert property (@(posedge clock) disable iff (reset)
      (peak_max_ff >= peak_min_ff) ||
      (peak_max_ff == '0 && peak_min_ff == ADC_MAX))
      else $error("peak minimum above peak maximum");

   // an average only comes with a closed window
   a_avg_with_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.avg_valid) |-> rsp_ff.level_valid)
      else $error("average without level");
`endif

endmodule
`default_nettype wire

// ----- sv/slm_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slm_ctrl
// Sequencer: accept, map, fixup, accumulate, optional divide, result load.
// ----------------------------------------------------------------------------
module slm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  slm_pkg::slm_status_type  status,
   output slm_pkg::slm_cmd_type     cmd
);
   import slm_pkg::*;

   slm_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = status.close ? S_MAP : S_OUT;
            end
         end
         S_MAP:   state_in = S_FIX;
         S_FIX:   state_in = S_ACCUM;
         S_ACCUM: state_in = status.avg_due ? S_DIV : S_OUT;
         S_DIV: begin
            if (status.div_last) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_MAP:   cmd.map      = 1'b1;
         S_FIX:   cmd.fix      = 1'b1;
         S_ACCUM: cmd.accum    = 1'b1;
         S_DIV:   cmd.div_step = 1'b1;
         S_OUT:   cmd.out_load = status.out_free;
         default: cmd          = '0;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/sound_level_meter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sound_level_meter
// Peak-to-peak sound level meter: window peaks, linear level map, band
// classification and periodic mean of levels.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  sample, ms_tick
//  rsp      out        rsp_valid/rsp_ready  level_valid, level_db, band,
//                                           avg_valid, avg_db_q4
//  csr      in/out     psel/penable/pready  six registers at 4*index
//
//  A transaction that does not close a window goes from accept to result load;
//  one that closes a window also passes reciprocal multiply, fixup, accumulate.
//  An emitted average adds a divide in the divider, one quotient bit per cycle.
//  The result register lets the next transaction start while a result waits;
//  only the result load stalls on rsp_ready.
//  Reset is synchronous and restores register defaults and an empty window.
// ----------------------------------------------------------------------------
module sound_level_meter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  slm_pkg::slm_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output slm_pkg::slm_rsp_type               rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [slm_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [slm_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [slm_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import slm_pkg::*;

   slm_cfg_type    cfg;
   slm_cmd_type    cmd;
   slm_status_type status;

   // configuration registers
   slm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer
   slm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   slm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
